// ----- sv/rhsc_pkg.sv -----
// Shared constants and types for the HSL shadow-color adjust block.
package rhsc_pkg;

    localparam int CHANNEL_BITS_DEF = 16;
    localparam int FRAC_BITS        = 24;
    localparam int HUE_BITS         = 16;
    localparam int SCALE_BITS       = 16;
    localparam int QUO_BITS         = FRAC_BITS + 1;

    localparam logic [1:0] CFG_HUE_OFFSET = 2'd0;
    localparam logic [1:0] CFG_SAT_SCALE  = 2'd1;
    localparam logic [1:0] CFG_LIG_SCALE  = 2'd2;

    localparam logic [15:0] HUE_OFFSET_RST = 16'd3277;
    localparam logic [15:0] SAT_SCALE_RST  = 16'd58982;
    localparam logic [15:0] LIG_SCALE_RST  = 16'd58982;

    typedef struct packed {
        logic [HUE_BITS-1:0]   hue_offset;
        logic [SCALE_BITS-1:0] sat_scale;
        logic [SCALE_BITS-1:0] lig_scale;
    } t_cfg;

    typedef struct packed {
        logic [1:0]          mode;
        logic [HUE_BITS:0]   w;
    } t_sext;

    localparam logic [1:0] SX_RISE = 2'd0;
    localparam logic [1:0] SX_FLAT = 2'd1;
    localparam logic [1:0] SX_FALL = 2'd2;
    localparam logic [1:0] SX_LOW  = 2'd3;

endpackage

// ----- sv/rhsc_in_if.sv -----
// Input pixel channel: valid/ready request carrying one RGBA pixel.
interface rhsc_in_if
    import rhsc_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;
    logic [CHANNEL_BITS-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

// ----- sv/rhsc_out_if.sv -----
// Output pixel channel: valid/ready request carrying one adjusted RGBA pixel.
interface rhsc_out_if
    import rhsc_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) ();
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;
    logic [CHANNEL_BITS-1:0] alpha_out;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

// ----- sv/rgb_hsl_shadow_color_core.sv -----
// Top level of the HSL shadow-color adjust pipeline.
//
// Channels: i_pix takes one RGBA pixel per request, o_pix returns one
// adjusted pixel per request, in order. Both use valid/ready.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0 hue offset, 1 saturation scale, 2 lightness scale); index 3 is ignored.
// Write only while the pipeline is empty.
// Pipeline: a pixel accepted on i_pix passes through one load stage and
// 25 quotient-bit stages of the saturation and hue dividers, with the
// lightness fold pipeline matched to the same 26 stages, then six stages
// of scaling and back conversion, before it appears on o_pix.
// Throughput: one pixel per cycle while the output is not stalled; the divider pipelines are the depth.
// Stall: the whole pipeline holds on one enable; while the output holds a
// result that is not taken, i_pix.ready is low and nothing moves. The
// pipeline advances whenever the output is empty or taken.
// Reset: clears all valid bits and loads the register reset values.
module rgb_hsl_shadow_color_core
    import rhsc_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    rhsc_in_if.sink     i_pix,
    rhsc_out_if.source  o_pix
);
    localparam int CB = CHANNEL_BITS;

    t_cfg r_cfg;
    logic en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue_offset <= HUE_OFFSET_RST;
            r_cfg.sat_scale  <= SAT_SCALE_RST;
            r_cfg.lig_scale  <= LIG_SCALE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HUE_OFFSET: r_cfg.hue_offset <= i_cfg_data;
                CFG_SAT_SCALE:  r_cfg.sat_scale  <= i_cfg_data;
                CFG_LIG_SCALE:  r_cfg.lig_scale  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [CB:0]             lig_sum;
    logic [CB+FRAC_BITS-1:0] sat_num;
    logic [CB-1:0]           sat_den;
    logic [CB+HUE_BITS+2:0]  hue_num;
    logic [CB+2:0]           hue_den;
    logic                    grey;

    rhsc_front #(.CB(CB)) u_front (
        .i_red     (i_pix.red_in),
        .i_green   (i_pix.green_in),
        .i_blue    (i_pix.blue_in),
        .o_sum     (lig_sum),
        .o_sat_num (sat_num),
        .o_sat_den (sat_den),
        .o_hue_num (hue_num),
        .o_hue_den (hue_den),
        .o_grey    (grey)
    );

    logic                in_req;
    logic                lig_v, sat_v, hue_v;
    logic [QUO_BITS-1:0] lig_q, sat_q, hue_q;
    logic [CB-1:0]       alpha_d;
    logic                sat_grey, hue_grey;

    assign in_req = i_pix.valid && en;

    rhsc_lig #(.CB(CB), .LAT(QUO_BITS+1), .PW(CB)) u_lig (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (in_req),
        .i_sum   (lig_sum),
        .i_pay   (i_pix.alpha_in),
        .o_vld   (lig_v),
        .o_lig   (lig_q),
        .o_pay   (alpha_d)
    );

    rhsc_div #(.NW(CB+FRAC_BITS), .DW(CB), .QW(QUO_BITS), .PW(1)) u_div_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (in_req),
        .i_num   (sat_num),
        .i_div   (sat_den),
        .i_pay   (grey),
        .o_vld   (sat_v),
        .o_q     (sat_q),
        .o_pay   (sat_grey)
    );

    rhsc_div #(.NW(CB+HUE_BITS+3), .DW(CB+3), .QW(QUO_BITS), .PW(1)) u_div_hue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (in_req),
        .i_num   (hue_num),
        .i_div   (hue_den),
        .i_pay   (grey),
        .o_vld   (hue_v),
        .o_q     (hue_q),
        .o_pay   (hue_grey)
    );

    logic out_v;

    rhsc_back #(.CB(CB)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_cfg      (r_cfg),
        .i_vld      (lig_v),
        .i_lig_q    (lig_q),
        .i_sat_q    (sat_q),
        .i_hue_q    (hue_q),
        .i_sat_grey (sat_grey),
        .i_hue_grey (hue_grey),
        .i_alpha    (alpha_d),
        .o_vld      (out_v),
        .o_red      (o_pix.red_out),
        .o_green    (o_pix.green_out),
        .o_blue     (o_pix.blue_out),
        .o_alpha    (o_pix.alpha_out)
    );

    assign en          = !out_v || o_pix.ready;
    assign i_pix.ready = en;
    assign o_pix.valid = out_v;

`ifndef SYNTH
    a_div_lanes_agree: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lig_v == sat_v) && (sat_v == hue_v))
        else $error("divider lanes out of step");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_v && !o_pix.ready) |-> !i_pix.ready)
        else $error("input taken while output stalled");

    a_stall_freezes_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(lig_v) && $stable(out_v)))
        else $error("pipeline moved during stall");
`endif
endmodule

// ----- sv/rhsc_front.sv -----
// RGB to HSL front end: max/min, sum, spread and the division operands.
module rhsc_front
    import rhsc_pkg::*;
#(
    parameter int CB = CHANNEL_BITS_DEF
) (
    input  logic [CB-1:0]           i_red,
    input  logic [CB-1:0]           i_green,
    input  logic [CB-1:0]           i_blue,
    output logic [CB:0]             o_sum,
    output logic [CB+FRAC_BITS-1:0] o_sat_num,
    output logic [CB-1:0]           o_sat_den,
    output logic [CB+HUE_BITS+2:0]  o_hue_num,
    output logic [CB+2:0]           o_hue_den,
    output logic                    o_grey
);
    localparam logic [CB-1:0] M = {CB{1'b1}};

    logic [CB-1:0] mx, mn, d, den;
    logic [CB:0]   sum;
    logic [CB+2:0] d3, hn;

    always_comb begin
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx) mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn) mn = i_blue;
        sum = {1'b0, mx} + {1'b0, mn};
        d   = mx - mn;
        d3  = (CB+3)'(d);
        if (sum > {1'b0, M}) begin
            den = CB'({M, 1'b0} - sum);
        end else begin
            den = sum[CB-1:0];
        end
        if (mx == i_red) begin
            if (i_green >= i_blue) begin
                hn = (CB+3)'(i_green - i_blue);
            end else begin
                hn = (d3 << 2) + (d3 << 1) - (CB+3)'(i_blue - i_green);
            end
        end else if (mx == i_green) begin
            hn = (d3 << 1) + (CB+3)'(i_blue) - (CB+3)'(i_red);
        end else begin
            hn = (d3 << 2) + (CB+3)'(i_red) - (CB+3)'(i_green);
        end
    end

    assign o_sum     = sum;
    assign o_sat_num = {d, {FRAC_BITS{1'b0}}} + (CB+FRAC_BITS)'(den >> 1);
    assign o_sat_den = den;
    assign o_hue_num = {hn, {HUE_BITS{1'b0}}} + (CB+HUE_BITS+3)'((d3 << 1) + d3);
    assign o_hue_den = (d3 << 2) + (d3 << 1);
    assign o_grey    = (d == '0);
endmodule

// ----- sv/rhsc_div.sv -----
// Pipelined restoring divider and fixed-divisor lightness pipeline, with side payload.
module rhsc_div
    import rhsc_pkg::*;
#(
    parameter int NW = 40,
    parameter int DW = 17,
    parameter int QW = QUO_BITS,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_div,
    input  logic [PW-1:0] i_pay,
    output logic          o_vld,
    output logic [QW-1:0] o_q,
    output logic [PW-1:0] o_pay
);
    logic [DW-1:0] r_rem [QW+1];
    logic [QW-1:0] r_nlo [QW+1];
    logic [QW-1:0] r_q   [QW+1];
    logic [DW-1:0] r_d   [QW+1];
    logic [PW-1:0] r_p   [QW+1];
    logic          r_v   [QW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num >> QW);
            r_nlo[0] <= i_num[QW-1:0];
            r_q[0]   <= '0;
            r_d[0]   <= i_div;
            r_p[0]   <= i_pay;
        end
    end

    for (genvar k = 1; k <= QW; k++) begin : g_step
        logic [DW:0] t, dif;
        logic        ge;

        always_comb begin
            t   = {r_rem[k-1], r_nlo[k-1][QW-1]};
            dif = t - {1'b0, r_d[k-1]};
            ge  = (t >= {1'b0, r_d[k-1]});
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= ge ? dif[DW-1:0] : t[DW-1:0];
                r_nlo[k] <= r_nlo[k-1] << 1;
                r_q[k]   <= {r_q[k-1][QW-2:0], ge};
                r_d[k]   <= r_d[k-1];
                r_p[k]   <= r_p[k-1];
            end
        end
    end

    assign o_vld = r_v[QW];
    assign o_q   = r_q[QW];
    assign o_pay = r_p[QW];
endmodule

module rhsc_lig
    import rhsc_pkg::*;
#(
    parameter int CB  = CHANNEL_BITS_DEF,
    parameter int LAT = QUO_BITS + 1,
    parameter int PW  = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_vld,
    input  logic [CB:0]         i_sum,
    input  logic [PW-1:0]       i_pay,
    output logic                o_vld,
    output logic [QUO_BITS-1:0] o_lig,
    output logic [PW-1:0]       o_pay
);
    // lig = (floor(sum * 2^F / M) + 1) / 2, M = 2^CB - 1, by folding CB-bit digits
    localparam int NF = (FRAC_BITS + CB) / CB + 3;
    localparam int DL = LAT - NF - 1;
    localparam int XW = CB + FRAC_BITS + 1;
    localparam int QB = FRAC_BITS + 2;
    localparam logic [XW-1:0] M = XW'({CB{1'b1}});

    logic [XW-1:0]       r_x [NF+1];
    logic [QB-1:0]       r_q [NF+1];
    logic [QUO_BITS-1:0] r_l [DL];
    logic [PW-1:0]       r_p [LAT];
    logic                r_v [LAT];
    logic [QB-1:0]       q_fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= {i_sum, {FRAC_BITS{1'b0}}};
            r_q[0] <= '0;
            r_p[0] <= i_pay;
        end
    end

    for (genvar k = 1; k <= NF; k++) begin : g_fold
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k] <= (r_x[k-1] >> CB) + (r_x[k-1] & M);
                r_q[k] <= r_q[k-1] + QB'(r_x[k-1] >> CB);
            end
        end
    end

    always_comb begin
        q_fin = r_q[NF] + QB'(r_x[NF] == M) + QB'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_l[0] <= q_fin[QB-1:1];
        end
    end

    for (genvar k = 1; k < DL; k++) begin : g_delay
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_l[k] <= r_l[k-1];
            end
        end
    end

    for (genvar k = 1; k < LAT; k++) begin : g_pipe
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= r_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k] <= r_p[k-1];
            end
        end
    end

    assign o_vld = r_v[LAT-1];
    assign o_lig = r_l[DL-1];
    assign o_pay = r_p[LAT-1];
endmodule

// ----- sv/rhsc_back.sv -----
// HSL scaling and HSL to RGB back end, six register stages.
module rhsc_back
    import rhsc_pkg::*;
#(
    parameter int CB = CHANNEL_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  t_cfg                i_cfg,
    input  logic                i_vld,
    input  logic [QUO_BITS-1:0] i_lig_q,
    input  logic [QUO_BITS-1:0] i_sat_q,
    input  logic [QUO_BITS-1:0] i_hue_q,
    input  logic                i_sat_grey,
    input  logic                i_hue_grey,
    input  logic [CB-1:0]       i_alpha,
    output logic                o_vld,
    output logic [CB-1:0]       o_red,
    output logic [CB-1:0]       o_green,
    output logic [CB-1:0]       o_blue,
    output logic [CB-1:0]       o_alpha
);
    localparam int F   = FRAC_BITS;
    localparam int SPW = QUO_BITS + SCALE_BITS;
    localparam int UW  = HUE_BITS + 3;
    localparam int WW  = HUE_BITS + 1;
    localparam int XW  = F + 1 + WW;
    localparam int CW  = F + 1 + CB;
    localparam logic [CB-1:0]  M    = {CB{1'b1}};
    localparam logic [UW:0]    SEXT = (UW+1)'(1) << HUE_BITS;

    function automatic t_sext sext(input logic [UW-1:0] pos);
        t_sext r;
        r.w = '0;
        if ({1'b0, pos} < SEXT) begin
            r.mode = SX_RISE;
            r.w    = WW'(pos);
        end else if ({1'b0, pos} < 3 * SEXT) begin
            r.mode = SX_FLAT;
        end else if ({1'b0, pos} < 4 * SEXT) begin
            r.mode = SX_FALL;
            r.w    = WW'(4 * SEXT - {1'b0, pos});
        end else begin
            r.mode = SX_LOW;
        end
        return r;
    endfunction

    // stage B: hue offset, S/L scale products
    logic [SPW-1:0]      r_b_sp, r_b_lp;
    logic [HUE_BITS-1:0] r_b_hue;
    logic [CB-1:0]       r_b_a;
    logic                r_b_v;
    logic [QUO_BITS-1:0] sat_b;
    logic [HUE_BITS-1:0] hue_b;

    always_comb begin
        sat_b = i_sat_grey ? '0 : i_sat_q;
        hue_b = i_hue_grey ? '0 : i_hue_q[HUE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_sp  <= SPW'(sat_b) * SPW'(i_cfg.sat_scale);
            r_b_lp  <= SPW'(i_lig_q) * SPW'(i_cfg.lig_scale);
            r_b_hue <= hue_b + i_cfg.hue_offset;
            r_b_a   <= i_alpha;
        end
    end

    // stage C: round scaled S/L, l*s product
    logic [2*F-1:0]      r_c_mp;
    logic [F-1:0]        r_c_s, r_c_l;
    logic [HUE_BITS-1:0] r_c_hue;
    logic [CB-1:0]       r_c_a;
    logic                r_c_v;
    logic [F-1:0]        s_c, l_c;

    always_comb begin
        s_c = F'((r_b_sp + (SPW'(1) << (SCALE_BITS-1))) >> SCALE_BITS);
        l_c = F'((r_b_lp + (SPW'(1) << (SCALE_BITS-1))) >> SCALE_BITS);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_mp  <= (2*F)'(s_c) * (2*F)'(l_c);
            r_c_s   <= s_c;
            r_c_l   <= l_c;
            r_c_hue <= r_b_hue;
            r_c_a   <= r_b_a;
        end
    end

    // stage D: p/q, sextant positions per channel
    logic [F:0]    r_d_p, r_d_q, r_d_diff;
    t_sext         r_d_sx [3];
    logic [CB-1:0] r_d_a;
    logic          r_d_v;
    logic [F:0]    m_d, l_d, s_d, p_d, q_d;
    logic [UW:0]   u_d, pr_d, pb_d;

    always_comb begin
        m_d = (F+1)'((r_c_mp + ((2*F)'(1) << (F-1))) >> F);
        l_d = (F+1)'(r_c_l);
        s_d = (F+1)'(r_c_s);
        if (r_c_l < (F'(1) << (F-1))) begin
            q_d = l_d + m_d;
            p_d = l_d - m_d;
        end else begin
            q_d = l_d + s_d - m_d;
            p_d = l_d + m_d - s_d;
        end
        u_d  = ((UW+1)'(r_c_hue) << 2) + ((UW+1)'(r_c_hue) << 1);
        pr_d = u_d + (SEXT << 1);
        if (pr_d >= (UW+1)'(6 * SEXT)) pr_d = pr_d - (UW+1)'(6 * SEXT);
        pb_d = u_d + (SEXT << 2);
        if (pb_d >= (UW+1)'(6 * SEXT)) pb_d = pb_d - (UW+1)'(6 * SEXT);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_p     <= p_d;
            r_d_q     <= q_d;
            r_d_diff  <= q_d - p_d;
            r_d_sx[0] <= sext(pr_d[UW-1:0]);
            r_d_sx[1] <= sext(u_d[UW-1:0]);
            r_d_sx[2] <= sext(pb_d[UW-1:0]);
            r_d_a     <= r_c_a;
        end
    end

    // stage E: ramp products
    logic [XW-1:0] r_e_x [3];
    logic [1:0]    r_e_mode [3];
    logic [F:0]    r_e_p, r_e_q;
    logic [CB-1:0] r_e_a;
    logic          r_e_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_e_x[i]    <= XW'(r_d_diff) * XW'(r_d_sx[i].w);
                r_e_mode[i] <= r_d_sx[i].mode;
            end
            r_e_p <= r_d_p;
            r_e_q <= r_d_q;
            r_e_a <= r_d_a;
        end
    end

    // stage F: channel value, scale to channel range
    logic [CW-1:0] r_f_c [3];
    logic [CB-1:0] r_f_a;
    logic          r_f_v;
    logic [F:0]    v_f [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            case (r_e_mode[i])
                SX_RISE, SX_FALL: begin
                    v_f[i] = r_e_p + (F+1)'((r_e_x[i] + (XW'(1) << (HUE_BITS-1))) >> HUE_BITS);
                end
                SX_FLAT: v_f[i] = r_e_q;
                default: v_f[i] = r_e_p;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_f_c[i] <= CW'(v_f[i]) * CW'(M);
            end
            r_f_a <= r_e_a;
        end
    end

    // stage G: round and saturate
    logic [CB-1:0] r_g_ch [3];
    logic [CB-1:0] r_g_a;
    logic          r_g_v;
    logic [CB:0]   ch_g [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ch_g[i] = (CB+1)'((r_f_c[i] + (CW'(1) << (F-1))) >> F);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_g_ch[i] <= (ch_g[i] > {1'b0, M}) ? M : ch_g[i][CB-1:0];
            end
            r_g_a <= r_f_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
            r_d_v <= 1'b0;
            r_e_v <= 1'b0;
            r_f_v <= 1'b0;
            r_g_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= i_vld;
            r_c_v <= r_b_v;
            r_d_v <= r_c_v;
            r_e_v <= r_d_v;
            r_f_v <= r_e_v;
            r_g_v <= r_f_v;
        end
    end

    assign o_vld   = r_g_v;
    assign o_red   = r_g_ch[0];
    assign o_green = r_g_ch[1];
    assign o_blue  = r_g_ch[2];
    assign o_alpha = r_g_a;
endmodule

// ----- sim/rhsc_scoreboard.sv -----
// Watches the pixel channels, predicts each adjusted pixel and compares it.
`timescale 1ns / 100ps
module rhsc_scoreboard
    import rhsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    rhsc_in_if          i_pix,
    rhsc_out_if         o_pix,
    output int          o_pending,
    output int          o_errors,
    output int          o_results
);
    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } t_pix;

    localparam longint unsigned ONE  = 64'd1 << FRAC_BITS;
    localparam longint unsigned HALF = 64'd1 << (FRAC_BITS - 1);
    localparam longint unsigned CMAX = 64'd65535;
    localparam longint unsigned SX   = 64'd65536;

    t_cfg cfg;
    t_pix adjusted_q[$];
    int   errors;
    int   results;

    assign o_pending = adjusted_q.size();
    assign o_errors  = errors;
    assign o_results = results;

    function automatic longint unsigned sext_level(longint unsigned p, longint unsigned q,
                                                   longint unsigned u);
        longint unsigned diff;
        diff = q - p;
        if (u < SX) return p + ((diff * u + SX / 2) >> 16);
        if (u < 3 * SX) return q;
        if (u < 4 * SX) return p + ((diff * (4 * SX - u) + SX / 2) >> 16);
        return p;
    endfunction

    function automatic logic [15:0] to_chan(longint unsigned v);
        longint unsigned c;
        c = (v * CMAX + HALF) >> FRAC_BITS;
        return (c > CMAX) ? 16'hFFFF : c[15:0];
    endfunction

    function automatic t_pix adjust_pixel(t_cfg c, logic [15:0] r16, logic [15:0] g16,
                                          logic [15:0] b16, logic [15:0] a16);
        longint unsigned r, g, b, mx, mn, sum, d, hue, sat, lig, den, hn, m, p, q, u;
        t_pix res;
        r = r16; g = g16; b = b16;
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        sum = mx + mn;
        d = mx - mn;
        hue = 0;
        sat = 0;
        lig = (sum * ONE + CMAX) / (2 * CMAX);
        if (d != 0) begin
            den = (sum > CMAX) ? (2 * CMAX - sum) : sum;
            sat = (d * ONE + den / 2) / den;
            if (mx == r) hn = (g >= b) ? (g - b) : (6 * d - (b - g));
            else if (mx == g) hn = 2 * d + b - r;
            else hn = 4 * d + r - g;
            hue = ((hn * 65536 + 3 * d) / (6 * d)) & 64'hFFFF;
        end
        hue = (hue + c.hue_offset) & 64'hFFFF;
        sat = (sat * c.sat_scale + 32768) >> 16;
        lig = (lig * c.lig_scale + 32768) >> 16;
        m = (lig * sat + HALF) >> FRAC_BITS;
        if (lig < HALF) begin
            q = lig + m;
            p = lig - m;
        end else begin
            q = lig + sat - m;
            p = lig + m - sat;
        end
        u = hue * 6;
        res.red   = to_chan(sext_level(p, q, (u + 2 * SX) % (6 * SX)));
        res.green = to_chan(sext_level(p, q, u));
        res.blue  = to_chan(sext_level(p, q, (u + 4 * SX) % (6 * SX)));
        res.alpha = a16;
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        t_pix want;
        if (!i_rst_n) begin
            cfg <= '{HUE_OFFSET_RST, SAT_SCALE_RST, LIG_SCALE_RST};
            errors <= 0;
            results <= 0;
            adjusted_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_HUE_OFFSET: cfg.hue_offset <= i_cfg_data;
                    CFG_SAT_SCALE:  cfg.sat_scale  <= i_cfg_data;
                    CFG_LIG_SCALE:  cfg.lig_scale  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_pix.valid && i_pix.ready)
                adjusted_q.push_back(adjust_pixel(cfg, i_pix.red_in, i_pix.green_in,
                                                  i_pix.blue_in, i_pix.alpha_in));
            if (o_pix.valid && o_pix.ready) begin
                results <= results + 1;
                if (adjusted_q.size() == 0) begin
                    $error("unexpected result: nothing pending");
                    errors <= errors + 1;
                end else begin
                    want = adjusted_q.pop_front();
                    if (o_pix.red_out !== want.red) begin
                        $error("red_out expected %0d actual %0d", want.red, o_pix.red_out);
                        errors <= errors + 1;
                    end else if (o_pix.green_out !== want.green) begin
                        $error("green_out expected %0d actual %0d", want.green,
                               o_pix.green_out);
                        errors <= errors + 1;
                    end else if (o_pix.blue_out !== want.blue) begin
                        $error("blue_out expected %0d actual %0d", want.blue, o_pix.blue_out);
                        errors <= errors + 1;
                    end else if (o_pix.alpha_out !== want.alpha) begin
                        $error("alpha_out expected %0d actual %0d", want.alpha,
                               o_pix.alpha_out);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

// ----- sim/rgb_hsl_shadow_color_core_test.sv -----
// Stimulus and verdict for the HSL shadow-color adjust block.
`timescale 1ns / 100ps
module rgb_hsl_shadow_color_core_test;
    import rhsc_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          pending;
    int          errors;
    int          results;
    int          sent;
    logic        idle_on;
    logic        hold_go;
    int          hold_cnt;
    int          stall_cnt;

    rhsc_in_if  pix_in ();
    rhsc_out_if pix_out ();

    rgb_hsl_shadow_color_core u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_pix(pix_in.sink), .o_pix(pix_out.source)
    );

    rhsc_scoreboard u_scoreboard (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_pix(pix_in), .o_pix(pix_out),
        .o_pending(pending), .o_errors(errors), .o_results(results)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pix_out.ready <= 1'b0;
            hold_cnt <= 0;
            stall_cnt <= 0;
        end else if (hold_go && hold_cnt == 0 && stall_cnt >= 0) begin
            hold_cnt <= 400;
            stall_cnt <= -1;
            pix_out.ready <= 1'b0;
        end else if (hold_cnt > 1) begin
            hold_cnt <= hold_cnt - 1;
            pix_out.ready <= 1'b0;
        end else if (hold_cnt == 1) begin
            hold_cnt <= 0;
            pix_out.ready <= 1'b1;
        end else if (!idle_on) begin
            pix_out.ready <= 1'b1;
        end else if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            pix_out.ready <= 1'b0;
        end else begin
            stall_cnt <= (stall_cnt < 0) ? -1 : gap_len();
            pix_out.ready <= 1'b1;
        end
    end

    task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                              logic [15:0] a);
        int  gap;
        logic ok;
        gap = idle_on ? gap_len() : 0;
        if (gap > 0) begin
            pix_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= r;
        pix_in.green_in <= g;
        pix_in.blue_in  <= b;
        pix_in.alpha_in <= a;
        do begin
            @(negedge i_clk);
            ok = pix_in.ready;
            @(posedge i_clk);
        end while (!ok);
        sent++;
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_cfg(logic [15:0] h, logic [15:0] s, logic [15:0] l);
        write_cfg(CFG_HUE_OFFSET, h);
        write_cfg(CFG_SAT_SCALE, s);
        write_cfg(CFG_LIG_SCALE, l);
        @(posedge i_clk);
    endtask

    task automatic random_pixels(int n);
        logic [15:0] r, g, b, a;
        int k;
        for (int i = 0; i < n; i++) begin
            r = 16'($urandom); g = 16'($urandom); b = 16'($urandom); a = 16'($urandom);
            k = $urandom_range(0, 9);
            if (k == 0) begin
                g = r; b = r;
            end else if (k == 1) begin
                g = r;
            end else if (k == 2) begin
                r = 16'(r[3:0]); g = 16'(g[3:0]); b = 16'(b[3:0]);
            end else if (k == 3) begin
                r = 16'hFFFF - r[3:0]; g = 16'hFFFF - g[3:0]; b = 16'hFFFF - b[3:0];
            end
            send_pixel(r, g, b, a);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_HUE_OFFSET;
        i_cfg_data = '0;
        pix_in.valid = 1'b0;
        pix_in.red_in = '0;
        pix_in.green_in = '0;
        pix_in.blue_in = '0;
        pix_in.alpha_in = '0;
        idle_on = 1'b0;
        hold_go = 1'b0;
        sent = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset settings
        send_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h1234);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'h0000);
        send_pixel(16'h0000, 16'h0000, 16'hFFFF, 16'hAAAA);
        send_pixel(16'hFFFF, 16'hFFFF, 16'h0000, 16'h5555);
        send_pixel(16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFE);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001, 16'h8000);
        send_pixel(16'h0001, 16'h0000, 16'h0000, 16'h7FFF);
        send_pixel(16'hFFFF, 16'hFFFE, 16'hFFFE, 16'h0000);
        send_pixel(16'h4000, 16'hC000, 16'h2000, 16'h0F0F);
        send_pixel(16'h7FFF, 16'h8000, 16'h7FFF, 16'hF0F0);
        drain();

        set_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001, 16'h0000);
        send_pixel(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
        send_pixel(16'h8000, 16'h8000, 16'h8000, 16'h0000);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        idle_on = 1'b1;
        random_pixels(80);
        drain();

        set_cfg(16'h0000, 16'h0000, 16'h0000);
        send_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        random_pixels(80);
        drain();

        set_cfg(16'h8000, 16'hFFFF, 16'h8000);
        hold_go = 1'b1;
        random_pixels(90);
        hold_go = 1'b0;
        drain();

        idle_on = 1'b0;
        set_cfg(16'h0000, 16'hFFFF, 16'hFFFF);
        random_pixels(90);
        drain();

        idle_on = 1'b1;
        set_cfg(16'($urandom), 16'($urandom), 16'($urandom));
        random_pixels(90);
        drain();

        set_cfg(HUE_OFFSET_RST, SAT_SCALE_RST, LIG_SCALE_RST);
        random_pixels(90);
        drain();

        $display("covered %0d pixels, %0d results, over seven register settings", sent,
                 results);
        $display("settings included all-zero and all-ones scales, hue wrap, long output stall");
        if (errors == 0 && pending == 0) begin
            $display("rgb_hsl_shadow_color_core_test: PASS");
        end else begin
            $display("rgb_hsl_shadow_color_core_test: FAIL");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("rgb_hsl_shadow_color_core_test: FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
sv/rhsc_pkg.sv
sv/rhsc_in_if.sv
sv/rhsc_out_if.sv
sv/rhsc_front.sv
sv/rhsc_div.sv
sv/rhsc_back.sv
sv/rgb_hsl_shadow_color_core.sv
sim/rhsc_scoreboard.sv
sim/rgb_hsl_shadow_color_core_test.sv
